// ===== sv/sag_pkg.sv =====
`default_nettype none

package sag_pkg;

    // Fixed geometry of the grid line logic.
    localparam int GRID_LINES = 8;
    localparam int HIST_SLOTS = 50;
    localparam int LINE_CNT_W = 4;
    localparam int LINE_IDX_W = 3;
    localparam int BIN_W      = $clog2(HIST_SLOTS);

    // 0.0005 and 0.001 in Q16.16.
    localparam int SPAN_TINY  = 33;
    localparam int WIDEN_HALF = 66;

    typedef enum logic [2:0] {
        CFG_OUTER_MIN      = 3'd0,
        CFG_OUTER_MAX      = 3'd1,
        CFG_INNER_MIN      = 3'd2,
        CFG_INNER_MAX      = 3'd3,
        CFG_SCOPE_PERIOD   = 3'd4,
        CFG_GRID_PERIOD    = 3'd5,
        CFG_GRID_ENABLE    = 3'd6,
        CFG_CAPTURE_ENABLE = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CLEAR, OP_WRITE,
        OP_EXT_INIT, OP_EXT_RD, OP_EXT_ACC, OP_EXT_FIN, OP_GRID_CHK,
        OP_G_INIT, OP_G_CLR,
        OP_H_INIT, OP_H_RD, OP_H_MUL, OP_H_DIV, OP_H_BRD, OP_H_BWR,
        OP_M_RD, OP_M_LD, OP_M_DIV, OP_M_WR,
        OP_S_LINE, OP_S_RD, OP_S_CHK, OP_S_UNQ, OP_S_END,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic cap_en;
        logic sw_zero;
        logic grid_go;
        logic fill_zero;
        logic idx_done;
        logic hdiv_last;
        logic mcnt_zero;
        logic mdiv_last;
        logic slot_last;
        logic grid_full;
        logic cand_ok;
        logic close;
        logic j_last;
        logic best_v;
        logic out_done;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/scope_autoscale_gridlines_unit.sv =====
`default_nettype none
// An ignored sample goes straight to its result words, a clear empties the window first, and a
// sample is written to the window, then may run an extent pass over the window entries and a grid
// pass (bin clear, histogram per entry, bin means, then line selection) before its result words.
// Throughput: one item at a time; the next is taken once its last result word is loaded.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, empties the window and
// restores the configuration defaults; window and bin memories are not cleared.

module scope_autoscale_gridlines_unit #(
    parameter int HISTORY_DEPTH = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Input words.
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // sample[31:0]
    input  wire logic          s_axis_tuser,   // func: 0 add sample, 1 clear window
    // Result words, one for each grid line held (at least one).
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [103:0]       m_axis_tdata,   // scope_min[31:0], scope_max[63:32],
                                               // line_count[67:64], line_index[70:68],
                                               // line_value[102:71], zero pad[103]
    output logic               m_axis_tlast,   // last
    // Configuration writes.
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);
    import sag_pkg::*;

    // The controller sequences the extent, histogram, mean and selection passes; the
    // datapath holds the window memory, the bin memory, both dividers and the line store.
    t_cmd  cmd;
    t_stat stat;

    sag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sag_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

`default_nettype wire

// ===== sv/sag_ctrl.sv =====
`default_nettype none

module sag_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  sag_pkg::t_stat      i_stat,
    output sag_pkg::t_cmd       o_cmd
);
    import sag_pkg::*;

    typedef enum logic [25:0] {
        ST_IDLE     = 26'b1 << 0,
        ST_CLEAR    = 26'b1 << 1,
        ST_WRITE    = 26'b1 << 2,
        ST_EXT_INIT = 26'b1 << 3,
        ST_EXT_RD   = 26'b1 << 4,
        ST_EXT_ACC  = 26'b1 << 5,
        ST_EXT_FIN  = 26'b1 << 6,
        ST_GRID_CHK = 26'b1 << 7,
        ST_G_INIT   = 26'b1 << 8,
        ST_G_CLR    = 26'b1 << 9,
        ST_H_INIT   = 26'b1 << 10,
        ST_H_RD     = 26'b1 << 11,
        ST_H_MUL    = 26'b1 << 12,
        ST_H_DIV    = 26'b1 << 13,
        ST_H_BRD    = 26'b1 << 14,
        ST_H_BWR    = 26'b1 << 15,
        ST_M_RD     = 26'b1 << 16,
        ST_M_LD     = 26'b1 << 17,
        ST_M_DIV    = 26'b1 << 18,
        ST_M_WR     = 26'b1 << 19,
        ST_S_LINE   = 26'b1 << 20,
        ST_S_RD     = 26'b1 << 21,
        ST_S_CHK    = 26'b1 << 22,
        ST_S_UNQ    = 26'b1 << 23,
        ST_S_END    = 26'b1 << 24,
        ST_OUT      = 26'b1 << 25
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_stat.func) n_state = ST_CLEAR;
                    else if (i_stat.cap_en) n_state = ST_WRITE;
                    else n_state = ST_OUT;
                end
            end
            ST_CLEAR:    n_state = ST_OUT;
            ST_WRITE:    n_state = i_stat.sw_zero ? ST_EXT_INIT : ST_GRID_CHK;
            ST_EXT_INIT: n_state = i_stat.fill_zero ? ST_EXT_FIN : ST_EXT_RD;
            ST_EXT_RD:   n_state = ST_EXT_ACC;
            ST_EXT_ACC:  n_state = i_stat.idx_done ? ST_EXT_FIN : ST_EXT_RD;
            ST_EXT_FIN:  n_state = ST_GRID_CHK;
            ST_GRID_CHK: n_state = i_stat.grid_go ? ST_G_INIT : ST_OUT;
            ST_G_INIT:   n_state = ST_G_CLR;
            ST_G_CLR:    n_state = i_stat.slot_last ? ST_H_INIT : ST_G_CLR;
            ST_H_INIT:   n_state = i_stat.fill_zero ? ST_M_RD : ST_H_RD;
            ST_H_RD:     n_state = ST_H_MUL;
            ST_H_MUL:    n_state = ST_H_DIV;
            ST_H_DIV:    n_state = i_stat.hdiv_last ? ST_H_BRD : ST_H_DIV;
            ST_H_BRD:    n_state = ST_H_BWR;
            ST_H_BWR:    n_state = i_stat.idx_done ? ST_M_RD : ST_H_RD;
            ST_M_RD:     n_state = ST_M_LD;
            ST_M_LD:     n_state = i_stat.mcnt_zero ? ST_M_WR : ST_M_DIV;
            ST_M_DIV:    n_state = i_stat.mdiv_last ? ST_M_WR : ST_M_DIV;
            ST_M_WR:     n_state = i_stat.slot_last ? ST_S_LINE : ST_M_RD;
            ST_S_LINE:   n_state = i_stat.grid_full ? ST_OUT : ST_S_RD;
            ST_S_RD:     n_state = ST_S_CHK;
            ST_S_CHK: begin
                if (i_stat.cand_ok) n_state = ST_S_UNQ;
                else n_state = i_stat.slot_last ? ST_S_END : ST_S_RD;
            end
            ST_S_UNQ: begin
                if (i_stat.close || i_stat.j_last)
                    n_state = i_stat.slot_last ? ST_S_END : ST_S_RD;
            end
            ST_S_END:    n_state = i_stat.best_v ? ST_S_LINE : ST_OUT;
            ST_OUT:      n_state = i_stat.out_done ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        o_cmd.accept = accept;
        case (r_state)
            ST_IDLE:     o_cmd.op = OP_IDLE;
            ST_CLEAR:    o_cmd.op = OP_CLEAR;
            ST_WRITE:    o_cmd.op = OP_WRITE;
            ST_EXT_INIT: o_cmd.op = OP_EXT_INIT;
            ST_EXT_RD:   o_cmd.op = OP_EXT_RD;
            ST_EXT_ACC:  o_cmd.op = OP_EXT_ACC;
            ST_EXT_FIN:  o_cmd.op = OP_EXT_FIN;
            ST_GRID_CHK: o_cmd.op = OP_GRID_CHK;
            ST_G_INIT:   o_cmd.op = OP_G_INIT;
            ST_G_CLR:    o_cmd.op = OP_G_CLR;
            ST_H_INIT:   o_cmd.op = OP_H_INIT;
            ST_H_RD:     o_cmd.op = OP_H_RD;
            ST_H_MUL:    o_cmd.op = OP_H_MUL;
            ST_H_DIV:    o_cmd.op = OP_H_DIV;
            ST_H_BRD:    o_cmd.op = OP_H_BRD;
            ST_H_BWR:    o_cmd.op = OP_H_BWR;
            ST_M_RD:     o_cmd.op = OP_M_RD;
            ST_M_LD:     o_cmd.op = OP_M_LD;
            ST_M_DIV:    o_cmd.op = OP_M_DIV;
            ST_M_WR:     o_cmd.op = OP_M_WR;
            ST_S_LINE:   o_cmd.op = OP_S_LINE;
            ST_S_RD:     o_cmd.op = OP_S_RD;
            ST_S_CHK:    o_cmd.op = OP_S_CHK;
            ST_S_UNQ:    o_cmd.op = OP_S_UNQ;
            ST_S_END:    o_cmd.op = OP_S_END;
            ST_OUT:      o_cmd.op = OP_OUT;
            default:     o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sag_dp.sv =====
`default_nettype none

module sag_dp #(
    parameter int HISTORY_DEPTH = 128
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  sag_pkg::t_cmd       i_cmd,
    output sag_pkg::t_stat      o_stat,
    input  wire logic [31:0]    i_s_tdata,
    input  wire logic           i_s_tuser,
    input  wire logic           i_m_tready,
    output logic                o_m_tvalid,
    output logic [103:0]        o_m_tdata,
    output logic                o_m_tlast,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data
);
    import sag_pkg::*;

    localparam int D     = HISTORY_DEPTH;
    localparam int AW    = $clog2(D);
    localparam int FW    = $clog2(D + 1);
    localparam int SW    = 32 + FW;
    localparam int QW    = BIN_W;
    localparam int DIVW  = 33 + QW;
    localparam int HSW   = $clog2(QW + 1);
    localparam int MSW   = $clog2(SW + 1);
    localparam int GW    = LINE_IDX_W;
    localparam int TW    = LINE_CNT_W;
    localparam logic [FW-1:0] THRESH = FW'((D / (GRID_LINES - 2)) / 4);
    localparam logic signed [DIVW-1:0] SLOT_MUL = DIVW'(HIST_SLOTS - 1);
    localparam logic [BIN_W-1:0] SLOT_MAX = BIN_W'(HIST_SLOTS - 1);

    // Configuration registers.
    logic signed [31:0] r_omin, r_omax, r_imin, r_imax;
    logic [7:0]         r_sper, r_gper;
    logic               r_gen, r_cap;

    // Window and extent state.
    logic signed [31:0] r_win_mem [D];
    logic signed [31:0] r_win_rd;
    logic [AW-1:0]      r_head, r_ptr;
    logic [FW-1:0]      r_fill, r_idx;
    logic signed [31:0] r_ext_lo, r_ext_hi, r_lo, r_hi;
    logic [7:0]         r_sw, r_gw;
    logic signed [31:0] r_sample;

    // Histogram bins: count in the upper field, sum (later the mean) below.
    logic [FW+SW-1:0]   r_bin_mem [HIST_SLOTS];
    logic [FW+SW-1:0]   r_bin_rd;
    logic [BIN_W-1:0]   r_slot;

    // Bin index divider.
    logic signed [32:0] r_span;
    logic [32:0]        r_span_mag;
    logic signed [31:0] r_hv;
    logic [DIVW-1:0]    r_hrem, r_hdsh;
    logic [QW-1:0]      r_hq;
    logic               r_hsat;
    logic [HSW-1:0]     r_hstep;

    // Bin mean divider.
    logic [SW-1:0]      r_mq;
    logic [FW-1:0]      r_mrem, r_mcnt;
    logic               r_mneg;
    logic [MSW-1:0]     r_mstep;

    // Grid line selection.
    logic signed [31:0] r_gs [GRID_LINES];
    logic [TW-1:0]      r_gtot;
    logic [GW-1:0]      r_j, r_k;
    logic [FW-1:0]      r_cand_c, r_best_c;
    logic signed [31:0] r_cand_m, r_best_m;
    logic [BIN_W-1:0]   r_best;
    logic               r_best_v;

    logic               r_mvalid;

    t_op op;
    assign op = i_cmd.op;

    // Extent fold of one window word, with the clamp to the outer bounds.
    logic signed [31:0] ext_lo_nx, ext_hi_nx;
    always_comb begin
        ext_lo_nx = r_lo;
        ext_hi_nx = r_hi;
        if (r_win_rd < r_lo) ext_lo_nx = (r_win_rd < r_omin) ? r_omin : r_win_rd;
        if (r_win_rd > r_hi) ext_hi_nx = (r_win_rd > r_omax) ? r_omax : r_win_rd;
    end

    // Narrow spans are widened around the floored midpoint.
    logic signed [32:0] fin_d, fin_mid;
    logic [32:0]        fin_ad;
    logic signed [33:0] fin_nl, fin_nh;
    logic signed [31:0] fin_lo, fin_hi;
    always_comb begin
        fin_d   = 33'(r_hi) - 33'(r_lo);
        fin_ad  = fin_d[32] ? 33'(-fin_d) : 33'(fin_d);
        fin_mid = (33'(r_hi) + 33'(r_lo)) >>> 1;
        fin_nl  = 34'(fin_mid) - 34'(WIDEN_HALF);
        fin_nh  = 34'(fin_mid) + 34'(WIDEN_HALF);
        fin_lo  = r_lo;
        fin_hi  = r_hi;
        if (fin_ad < 33'(SPAN_TINY)) begin
            fin_lo = (fin_nl < 34'(r_omin)) ? r_omin : fin_nl[31:0];
            fin_hi = (fin_nh > 34'(r_omax)) ? r_omax : fin_nh[31:0];
        end
    end

    // Scaled offset of a sample from the extent low edge.
    logic signed [DIVW-1:0] h_num;
    logic [DIVW-1:0]        h_mag;
    always_comb begin
        h_num = DIVW'(33'(r_win_rd) - 33'(r_ext_lo)) * SLOT_MUL;
        h_mag = h_num[DIVW-1] ? DIVW'(-h_num) : DIVW'(h_num);
        if (h_num[DIVW-1] != r_span[32]) h_mag = '0;
    end

    logic [BIN_W-1:0] h_bin;
    assign h_bin = (r_hsat || (r_hq > SLOT_MAX)) ? SLOT_MAX : r_hq;

    logic [FW-1:0]        rd_cnt;
    logic signed [SW-1:0] rd_sum;
    assign rd_cnt = r_bin_rd[SW +: FW];
    assign rd_sum = r_bin_rd[SW-1:0];

    // Restoring step of the mean divider.
    logic [FW:0]   m_trial;
    logic          m_bit;
    logic [FW-1:0] m_rem_nx;
    always_comb begin
        m_trial  = {r_mrem, r_mq[SW-1]};
        m_bit    = (m_trial >= {1'b0, r_mcnt});
        m_rem_nx = m_bit ? FW'(m_trial - {1'b0, r_mcnt}) : m_trial[FW-1:0];
    end

    logic [SW-1:0]      m_sq;
    logic signed [31:0] m_mean;
    assign m_sq   = r_mneg ? SW'(-r_mq) : r_mq;
    assign m_mean = m_sq[31:0];

    // Spacing test against the grid line at the read index.
    logic [GW-1:0]      gs_idx;
    logic signed [31:0] gs_rd;
    logic signed [32:0] u_diff;
    logic [32:0]        u_abs;
    logic               u_close;
    assign gs_idx  = (op == OP_OUT) ? r_k : r_j;
    assign gs_rd   = r_gs[gs_idx];
    assign u_diff  = 33'(r_cand_m) - 33'(gs_rd);
    assign u_abs   = u_diff[32] ? 33'(-u_diff) : 33'(u_diff);
    assign u_close = !r_span[32] && ({u_abs, 3'b000} < 36'(r_span[32:0]));

    logic cand_ok, j_last, slot_last;
    assign cand_ok   = (!r_best_v || (rd_cnt > r_best_c)) && (rd_cnt > THRESH);
    assign j_last    = (TW'(r_j) + 1'b1) == r_gtot;
    assign slot_last = (r_slot == SLOT_MAX);

    logic out_last, out_load;
    assign out_last = (r_gtot == '0) || ((TW'(r_k) + 1'b1) == r_gtot);
    assign out_load = (op == OP_OUT) && (!r_mvalid || i_m_tready);

    always_comb begin
        o_stat.func      = i_s_tuser;
        o_stat.cap_en    = r_cap;
        o_stat.sw_zero   = (r_sw == '0);
        o_stat.grid_go   = (r_gw == '0) && r_gen && (r_ext_lo != r_ext_hi);
        o_stat.fill_zero = (r_fill == '0);
        o_stat.idx_done  = (r_idx == r_fill);
        o_stat.hdiv_last = (r_hstep == '0);
        o_stat.mcnt_zero = (rd_cnt == '0);
        o_stat.mdiv_last = (r_mstep == MSW'(1));
        o_stat.slot_last = slot_last;
        o_stat.grid_full = (r_gtot >= TW'(GRID_LINES));
        o_stat.cand_ok   = cand_ok;
        o_stat.close     = u_close;
        o_stat.j_last    = j_last;
        o_stat.best_v    = r_best_v;
        o_stat.out_done  = out_load && out_last;
    end

    // Window memory: one write, one registered read.
    always_ff @(posedge i_clk) begin
        if (op == OP_WRITE)
            r_win_mem[(r_head == AW'(D - 1)) ? '0 : r_head + 1'b1] <= r_sample;
        r_win_rd <= r_win_mem[r_ptr];
    end

    // Bin memory: one write, one registered read.
    logic             bin_we;
    logic [BIN_W-1:0] bin_wa, bin_ra;
    logic [FW+SW-1:0] bin_wd;
    always_comb begin
        bin_we = 1'b0;
        bin_wa = r_slot;
        bin_wd = '0;
        case (op)
            OP_G_CLR: bin_we = 1'b1;
            OP_H_BWR: begin
                bin_we = 1'b1;
                bin_wa = h_bin;
                bin_wd = {rd_cnt + 1'b1, rd_sum + SW'(r_hv)};
            end
            OP_M_WR: begin
                bin_we = 1'b1;
                bin_wd = {r_mcnt, SW'(m_mean)};
            end
            OP_S_END: begin
                bin_we = r_best_v;
                bin_wa = r_best;
                bin_wd = {FW'(0), SW'(r_best_m)};
            end
            default: bin_we = 1'b0;
        endcase
        bin_ra = (op == OP_H_BRD) ? h_bin : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) r_bin_mem[bin_wa] <= bin_wd;
        r_bin_rd <= r_bin_mem[bin_ra];
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omin <= '0;
            r_omax <= '0;
            r_imin <= '0;
            r_imax <= '0;
            r_sper <= 8'd1;
            r_gper <= 8'd5;
            r_gen <= 1'b1;
            r_cap <= 1'b0;
            r_head <= '0;
            r_fill <= '0;
            r_ext_lo <= '0;
            r_ext_hi <= '0;
            r_sw <= '0;
            r_gw <= '0;
            r_gtot <= '0;
            r_mvalid <= 1'b0;
        end else begin
            case (op)
                OP_CLEAR: begin
                    r_head <= '0;
                    r_fill <= '0;
                    r_ext_lo <= r_imin;
                    r_ext_hi <= r_imax;
                end
                OP_WRITE: begin
                    r_head <= (r_head == AW'(D - 1)) ? '0 : r_head + 1'b1;
                    if (r_fill != FW'(D)) r_fill <= r_fill + 1'b1;
                    r_sw <= (r_sw == '0) ? r_sper : r_sw - 1'b1;
                end
                OP_EXT_FIN: begin
                    r_ext_lo <= fin_lo;
                    r_ext_hi <= fin_hi;
                end
                OP_GRID_CHK: r_gw <= (r_gw == '0) ? r_gper : r_gw - 1'b1;
                OP_G_INIT: r_gtot <= TW'(2);
                OP_S_END: if (r_best_v) r_gtot <= r_gtot + 1'b1;
                default: r_gtot <= r_gtot;
            endcase
            if (out_load) r_mvalid <= 1'b1;
            else if (i_m_tready) r_mvalid <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OUTER_MIN:      r_omin <= i_cfg_data;
                    CFG_OUTER_MAX:      r_omax <= i_cfg_data;
                    CFG_INNER_MIN: begin
                        r_imin <= i_cfg_data;
                        r_ext_lo <= i_cfg_data;
                    end
                    CFG_INNER_MAX: begin
                        r_imax <= i_cfg_data;
                        r_ext_hi <= i_cfg_data;
                    end
                    CFG_SCOPE_PERIOD:   r_sper <= i_cfg_data[7:0];
                    CFG_GRID_PERIOD:    r_gper <= i_cfg_data[7:0];
                    CFG_GRID_ENABLE:    r_gen <= i_cfg_data[0];
                    CFG_CAPTURE_ENABLE: r_cap <= i_cfg_data[0];
                    default:            r_cap <= r_cap;
                endcase
            end
        end
    end

    // Working registers of the passes and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_sample <= i_s_tdata;
        if (op != OP_OUT) r_k <= '0;
        case (op)
            OP_EXT_INIT: begin
                r_lo <= r_imin;
                r_hi <= r_imax;
                r_ptr <= r_head;
                r_idx <= '0;
            end
            OP_EXT_RD, OP_H_RD: begin
                r_ptr <= (r_ptr == '0) ? AW'(D - 1) : r_ptr - 1'b1;
                r_idx <= r_idx + 1'b1;
            end
            OP_EXT_ACC: begin
                r_lo <= ext_lo_nx;
                r_hi <= ext_hi_nx;
            end
            OP_G_INIT: begin
                r_span <= 33'(r_ext_hi) - 33'(r_ext_lo);
                r_span_mag <= (r_ext_hi < r_ext_lo) ? 33'(r_ext_lo) - 33'(r_ext_hi)
                                                    : 33'(r_ext_hi) - 33'(r_ext_lo);
                r_gs[0] <= r_ext_lo;
                r_gs[1] <= r_ext_hi;
                r_slot <= '0;
            end
            OP_G_CLR, OP_M_WR: r_slot <= r_slot + 1'b1;
            OP_H_INIT: begin
                r_ptr <= r_head;
                r_idx <= '0;
                r_slot <= '0;
            end
            OP_H_MUL: begin
                r_hv <= r_win_rd;
                r_hrem <= h_mag;
                r_hdsh <= DIVW'(r_span_mag) << QW;
                r_hq <= '0;
                r_hsat <= 1'b0;
                r_hstep <= HSW'(QW);
            end
            OP_H_DIV: begin
                if (r_hstep == HSW'(QW)) begin
                    r_hsat <= (r_hrem >= r_hdsh);
                end else if (r_hrem >= r_hdsh) begin
                    r_hrem <= r_hrem - r_hdsh;
                    r_hq <= QW'({r_hq, 1'b1});
                end else begin
                    r_hq <= QW'({r_hq, 1'b0});
                end
                r_hdsh <= r_hdsh >> 1;
                r_hstep <= r_hstep - 1'b1;
            end
            OP_M_LD: begin
                r_mcnt <= rd_cnt;
                r_mneg <= rd_sum[SW-1];
                r_mq <= (rd_cnt == '0) ? '0 : (rd_sum[SW-1] ? SW'(-rd_sum) : SW'(rd_sum));
                r_mrem <= '0;
                r_mstep <= MSW'(SW);
            end
            OP_M_DIV: begin
                r_mrem <= m_rem_nx;
                r_mq <= {r_mq[SW-2:0], m_bit};
                r_mstep <= r_mstep - 1'b1;
            end
            OP_S_LINE: begin
                r_best_v <= 1'b0;
                r_slot <= '0;
            end
            OP_S_CHK: begin
                r_cand_c <= rd_cnt;
                r_cand_m <= rd_sum[31:0];
                r_j <= '0;
                if (!cand_ok) r_slot <= r_slot + 1'b1;
            end
            OP_S_UNQ: begin
                if (u_close) begin
                    r_slot <= r_slot + 1'b1;
                end else if (j_last) begin
                    r_best_v <= 1'b1;
                    r_best <= r_slot;
                    r_best_c <= r_cand_c;
                    r_best_m <= r_cand_m;
                    r_slot <= r_slot + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            OP_S_END: if (r_best_v) r_gs[r_gtot[GW-1:0]] <= r_best_m;
            OP_OUT: begin
                if (out_load) begin
                    o_m_tdata <= {1'b0,
                                  (r_gtot == '0) ? 32'sd0 : gs_rd,
                                  r_k, r_gtot, r_ext_hi, r_ext_lo};
                    o_m_tlast <= out_last;
                    r_k <= r_k + 1'b1;
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign o_m_tvalid = r_mvalid;

endmodule

`default_nettype wire
